@@ rtl/assert_macros.svh @@
// Assertion macros included by the transform RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ntt_pkg.sv @@
// Types and constants of the number theoretic transform block
package ntt_pkg;

	localparam int unsigned DW = 62;
	localparam int unsigned LG_W = 4;
	localparam int unsigned S_W = 5;
	localparam int unsigned CFG_AW = 2;

	// register indexes
	localparam logic [CFG_AW-1:0] REG_MODULUS = 2'd0;
	localparam logic [CFG_AW-1:0] REG_ROOT = 2'd1;
	localparam logic [CFG_AW-1:0] REG_INVERSE = 2'd2;
	localparam logic [CFG_AW-1:0] REG_LOG = 2'd3;

	// item kinds
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [DW-1:0] RST_MODULUS = 62'd998244353;
	localparam logic [DW-1:0] RST_ROOT = 62'd3;
	localparam logic [LG_W-1:0] RST_LOG = 4'd10;

	typedef enum logic [28:0] {
		S_IDLE = 29'd1 << 0,
		S_RD_OUT = 29'd1 << 1,
		S_G_RED = 29'd1 << 2,
		S_G_SET = 29'd1 << 3,
		S_RED_RD = 29'd1 << 4,
		S_RED_MUL = 29'd1 << 5,
		S_RED_WR = 29'd1 << 6,
		S_BR_RD = 29'd1 << 7,
		S_BR_W1 = 29'd1 << 8,
		S_BR_W2 = 29'd1 << 9,
		S_ST_START = 29'd1 << 10,
		S_ST_INV = 29'd1 << 11,
		S_ST_WSET = 29'd1 << 12,
		S_TW_MUL = 29'd1 << 13,
		S_TW_WR = 29'd1 << 14,
		S_BF_RD = 29'd1 << 15,
		S_BF_MUL = 29'd1 << 16,
		S_BF_WR1 = 29'd1 << 17,
		S_BF_WR2 = 29'd1 << 18,
		S_INV_START = 29'd1 << 19,
		S_INV_P = 29'd1 << 20,
		S_SC_RD = 29'd1 << 21,
		S_SC_MUL = 29'd1 << 22,
		S_SC_WR = 29'd1 << 23,
		S_P_CHK = 29'd1 << 24,
		S_P_SQ1 = 29'd1 << 25,
		S_P_SQ = 29'd1 << 26,
		S_P_SQ2 = 29'd1 << 27,
		S_MUL = 29'd1 << 28
	} state_t;

endpackage

@@ rtl/number_theoretic_transform.sv @@
// Radix-2 number theoretic transform with a shared bit-serial modular multiplier
// Load item: written to the coefficient store on acceptance. Read item: result goes to the output register
// from S_RD_OUT once that register is free or taken. The load completing a batch starts the transform;
// every modular multiply runs in the shared shift-and-add unit, which sets the transform time: reduce,
// reorder, then per stage the twiddle powers, the twiddle table and the butterflies, then for the
// inverse one power and the 1/n scaling. Busy (not ready) throughout.
// arst_n clears control state and config registers; the stores are undefined until written.
module number_theoretic_transform #(
	parameter int unsigned MAX_POINTS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [ntt_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [ntt_pkg::DW-1:0]        cfg_data,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [71:0]                   s_tdata,  // coeff[61:0], index[71:62]
	input  logic                          s_tuser,  // cmd
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [63:0]                   m_tdata,  // value[61:0], zero pad
	output logic                          m_tuser   // bad_index
);

	localparam int unsigned DW = ntt_pkg::DW;
	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned IW = AW + 1;
	localparam int unsigned LGMAX = $clog2(MAX_POINTS + 1) - 1;
	localparam int unsigned CW = ((AW > 10) ? AW : 10) + 1;

	ntt_pkg::state_t state_q, mul_ret_q, pow_ret_q;

	// config registers
	logic [DW-1:0] cfg_mod_q, cfg_root_q;
	logic cfg_inv_q;
	logic [ntt_pkg::LG_W-1:0] cfg_log_q;

	// transform context
	logic [DW-1:0] m_q, g_q, w_q, t_q, d_q;
	logic [ntt_pkg::LG_W-1:0] lg_q;
	logic [IW-1:0] n_q, i_q, j_q, rev_q, load_cnt_q;
	logic [ntt_pkg::S_W-1:0] s_q;
	logic inv_q;

	// shared multiplier and power registers
	logic [DW-1:0] ma_q, mb_q, mr_q, pr_q, pb_q, pe_q;
	logic [5:0] mcnt_q;

	// output register
	logic ov_q, obad_q, rbad_q;
	logic [DW-1:0] oval_q;

	// memories
	logic [DW-1:0] coeff_mem [MAX_POINTS];
	logic [DW-1:0] tw_mem [MAX_POINTS];
	logic [DW-1:0] rd_a_q, rd_b_q, tw_rd_q;

	logic ce_we, rd_en, tw_we;
	logic [AW-1:0] ce_wa, ra_a, ra_b, tw_wa, tw_ra;
	logic [DW-1:0] ce_wd, tw_wd;

	logic [DW-1:0] in_coeff;
	logic [9:0] in_index;
	logic in_acc;

	logic [ntt_pkg::LG_W-1:0] eff_lg;
	logic [IW-1:0] n_eff, cnt_next, half, len, ij, ijh;
	logic [CW-1:0] idx_ext;
	logic [LGMAX-1:0] rev_full;
	logic [IW-1:0] rev;
	logic [DW-1:0] one_m, exp_stage, exp_inv;
	logic [DW:0] r2, r2b, r3, r4, bf_sum, bf_s;
	logic [DW-1:0] bf_d;

	assign in_coeff = s_tdata[61:0];
	assign in_index = s_tdata[71:62];
	assign in_acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ntt_pkg::S_IDLE);

	assign m_tvalid = ov_q;
	assign m_tdata = {2'b00, oval_q};
	assign m_tuser = obad_q;

	// effective size
	assign eff_lg = ({1'b0, cfg_log_q} > (ntt_pkg::LG_W + 1)'(LGMAX)) ?
		ntt_pkg::LG_W'(LGMAX) : cfg_log_q;
	assign n_eff = IW'(1) << eff_lg;
	assign cnt_next = load_cnt_q + IW'(1);
	assign idx_ext = CW'(in_index);

	// stage geometry
	assign len = IW'(1) << s_q;
	assign half = IW'(1) << (s_q - ntt_pkg::S_W'(1));
	assign ij = i_q + j_q;
	assign ijh = ij + half;

	// bit reversal of i over lg bits
	always_comb begin
		for (int k = 0; k < LGMAX; k++) begin
			rev_full[LGMAX-1-k] = i_q[k];
		end
	end
	assign rev = IW'(rev_full >> (ntt_pkg::LG_W'(LGMAX) - lg_q));

	assign one_m = (m_q == DW'(1)) ? '0 : DW'(1);
	assign exp_stage = (m_q - DW'(1)) >> s_q;
	assign exp_inv = (m_q >= DW'(2)) ? (m_q - DW'(2)) : '0;

	// one shift-and-add step of the modular multiplier
	always_comb begin
		r2 = {mr_q, 1'b0};
		r2b = (r2 >= {1'b0, m_q}) ? (r2 - {1'b0, m_q}) : r2;
		r3 = r2b + (mb_q[DW-1] ? {1'b0, ma_q} : '0);
		r4 = (r3 >= {1'b0, m_q}) ? (r3 - {1'b0, m_q}) : r3;
	end

	// butterfly sum and difference
	always_comb begin
		bf_sum = {1'b0, rd_a_q} + {1'b0, mr_q};
		bf_s = (bf_sum >= {1'b0, m_q}) ? (bf_sum - {1'b0, m_q}) : bf_sum;
		bf_d = (rd_a_q >= mr_q) ? (rd_a_q - mr_q) : (rd_a_q + m_q - mr_q);
	end

	// memory port selection
	always_comb begin
		ce_we = 1'b0;
		ce_wa = load_cnt_q[AW-1:0];
		ce_wd = in_coeff;
		rd_en = 1'b0;
		ra_a = i_q[AW-1:0];
		ra_b = rev[AW-1:0];
		tw_we = 1'b0;
		tw_wa = half[AW-1:0];
		tw_wd = one_m;
		tw_ra = ij[AW-1:0];
		case (state_q)
			ntt_pkg::S_IDLE: begin
				if (in_acc && s_tuser == ntt_pkg::CMD_LOAD) begin
					ce_we = (load_cnt_q < IW'(MAX_POINTS));
				end
				if (in_acc && s_tuser == ntt_pkg::CMD_READ) begin
					rd_en = 1'b1;
					ra_a = idx_ext[AW-1:0];
				end
			end
			ntt_pkg::S_RED_RD, ntt_pkg::S_SC_RD: begin
				rd_en = 1'b1;
			end
			ntt_pkg::S_RED_WR, ntt_pkg::S_SC_WR: begin
				ce_we = 1'b1;
				ce_wa = i_q[AW-1:0];
				ce_wd = mr_q;
			end
			ntt_pkg::S_BR_RD: begin
				rd_en = 1'b1;
			end
			ntt_pkg::S_BR_W1: begin
				ce_we = 1'b1;
				ce_wa = i_q[AW-1:0];
				ce_wd = rd_b_q;
			end
			ntt_pkg::S_BR_W2: begin
				ce_we = 1'b1;
				ce_wa = rev_q[AW-1:0];
				ce_wd = rd_a_q;
			end
			ntt_pkg::S_ST_WSET: begin
				tw_we = 1'b1;
			end
			ntt_pkg::S_TW_WR: begin
				tw_we = 1'b1;
				tw_wa = ijh[AW-1:0];
				tw_wd = mr_q;
			end
			ntt_pkg::S_BF_RD: begin
				rd_en = 1'b1;
				ra_a = ij[AW-1:0];
				ra_b = ijh[AW-1:0];
				tw_ra = half[AW-1:0] + j_q[AW-1:0];
			end
			ntt_pkg::S_BF_WR1: begin
				ce_we = 1'b1;
				ce_wa = ij[AW-1:0];
				ce_wd = bf_s[DW-1:0];
			end
			ntt_pkg::S_BF_WR2: begin
				ce_we = 1'b1;
				ce_wa = ijh[AW-1:0];
				ce_wd = d_q;
			end
			default: begin
			end
		endcase
	end

	// coefficient and twiddle stores
	always_ff @(posedge clk) begin
		if (ce_we) begin
			coeff_mem[ce_wa] <= ce_wd;
		end
		if (rd_en) begin
			rd_a_q <= coeff_mem[ra_a];
			rd_b_q <= coeff_mem[ra_b];
		end
		if (tw_we) begin
			tw_mem[tw_wa] <= tw_wd;
		end
		tw_rd_q <= tw_mem[tw_ra];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mod_q <= ntt_pkg::RST_MODULUS;
			cfg_root_q <= ntt_pkg::RST_ROOT;
			cfg_inv_q <= 1'b0;
			cfg_log_q <= ntt_pkg::RST_LOG;
		end else if (cfg_we) begin
			case (cfg_addr)
				ntt_pkg::REG_MODULUS: cfg_mod_q <= cfg_data;
				ntt_pkg::REG_ROOT: cfg_root_q <= cfg_data;
				ntt_pkg::REG_INVERSE: cfg_inv_q <= cfg_data[0];
				ntt_pkg::REG_LOG: cfg_log_q <= cfg_data[ntt_pkg::LG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == ntt_pkg::S_RD_OUT && (!ov_q || m_tready)) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ntt_pkg::S_RD_OUT && (!ov_q || m_tready)) begin
			obad_q <= rbad_q;
			oval_q <= rbad_q ? '0 : rd_a_q;
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ntt_pkg::S_IDLE: begin
				if (in_acc && s_tuser == ntt_pkg::CMD_READ) begin
					rbad_q <= (idx_ext >= CW'(n_eff));
				end
				if (in_acc && s_tuser == ntt_pkg::CMD_LOAD && cnt_next >= n_eff) begin
					m_q <= (cfg_mod_q < DW'(2)) ? DW'(1) : cfg_mod_q;
					lg_q <= eff_lg;
					n_q <= n_eff;
					inv_q <= cfg_inv_q;
				end
			end
			ntt_pkg::S_G_RED: begin
				ma_q <= DW'(1);
				mb_q <= cfg_root_q;
				mr_q <= '0;
			end
			ntt_pkg::S_G_SET: g_q <= mr_q;
			ntt_pkg::S_RED_MUL: begin
				ma_q <= DW'(1);
				mb_q <= rd_a_q;
				mr_q <= '0;
			end
			ntt_pkg::S_BR_RD: rev_q <= rev;
			ntt_pkg::S_ST_START: begin
				pr_q <= one_m;
				pb_q <= g_q;
				pe_q <= exp_stage;
			end
			// forward stage keeps the root in pr_q
			ntt_pkg::S_ST_INV: begin
				if (inv_q) begin
					pb_q <= pr_q;
					pr_q <= one_m;
					pe_q <= exp_inv;
				end
			end
			ntt_pkg::S_ST_WSET: begin
				w_q <= pr_q;
				t_q <= one_m;
			end
			ntt_pkg::S_TW_MUL: begin
				ma_q <= t_q;
				mb_q <= w_q;
				mr_q <= '0;
			end
			ntt_pkg::S_TW_WR: t_q <= mr_q;
			ntt_pkg::S_BF_MUL: begin
				ma_q <= rd_b_q;
				mb_q <= tw_rd_q;
				mr_q <= '0;
			end
			ntt_pkg::S_BF_WR1: d_q <= bf_d;
			ntt_pkg::S_INV_START: begin
				ma_q <= DW'(1);
				mb_q <= DW'(n_q);
				mr_q <= '0;
			end
			ntt_pkg::S_INV_P: begin
				pr_q <= one_m;
				pb_q <= mr_q;
				pe_q <= exp_inv;
			end
			ntt_pkg::S_SC_MUL: begin
				ma_q <= rd_a_q;
				mb_q <= pr_q;
				mr_q <= '0;
			end
			ntt_pkg::S_P_CHK: begin
				ma_q <= pr_q;
				mb_q <= pb_q;
				mr_q <= '0;
			end
			ntt_pkg::S_P_SQ1: pr_q <= mr_q;
			ntt_pkg::S_P_SQ: begin
				ma_q <= pb_q;
				mb_q <= pb_q;
				mr_q <= '0;
			end
			ntt_pkg::S_P_SQ2: begin
				pb_q <= mr_q;
				pe_q <= pe_q >> 1;
			end
			ntt_pkg::S_MUL: begin
				mr_q <= r4[DW-1:0];
				mb_q <= mb_q << 1;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ntt_pkg::S_IDLE;
			mul_ret_q <= ntt_pkg::S_IDLE;
			pow_ret_q <= ntt_pkg::S_IDLE;
			load_cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			s_q <= '0;
			mcnt_q <= '0;
		end else begin
			case (state_q)
				ntt_pkg::S_IDLE: begin
					if (in_acc && s_tuser == ntt_pkg::CMD_READ) begin
						state_q <= ntt_pkg::S_RD_OUT;
					end else if (in_acc) begin
						if (cnt_next >= n_eff) begin
							load_cnt_q <= '0;
							state_q <= ntt_pkg::S_G_RED;
						end else begin
							load_cnt_q <= cnt_next;
						end
					end
				end
				ntt_pkg::S_RD_OUT: begin
					if (!ov_q || m_tready) begin
						state_q <= ntt_pkg::S_IDLE;
					end
				end
				ntt_pkg::S_G_RED: begin
					mcnt_q <= '0;
					mul_ret_q <= ntt_pkg::S_G_SET;
					state_q <= ntt_pkg::S_MUL;
				end
				ntt_pkg::S_G_SET: begin
					i_q <= '0;
					state_q <= ntt_pkg::S_RED_RD;
				end
				// reduce every coefficient below the modulus
				ntt_pkg::S_RED_RD: state_q <= ntt_pkg::S_RED_MUL;
				ntt_pkg::S_RED_MUL: begin
					mcnt_q <= '0;
					mul_ret_q <= ntt_pkg::S_RED_WR;
					state_q <= ntt_pkg::S_MUL;
				end
				ntt_pkg::S_RED_WR: begin
					if (i_q + IW'(1) == n_q) begin
						i_q <= '0;
						state_q <= ntt_pkg::S_BR_RD;
					end else begin
						i_q <= i_q + IW'(1);
						state_q <= ntt_pkg::S_RED_RD;
					end
				end
				// bit-reversal reordering
				ntt_pkg::S_BR_RD: begin
					if (i_q < rev) begin
						state_q <= ntt_pkg::S_BR_W1;
					end else if (i_q + IW'(1) == n_q) begin
						s_q <= ntt_pkg::S_W'(1);
						state_q <= ntt_pkg::S_ST_START;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				ntt_pkg::S_BR_W1: state_q <= ntt_pkg::S_BR_W2;
				ntt_pkg::S_BR_W2: begin
					if (i_q + IW'(1) == n_q) begin
						s_q <= ntt_pkg::S_W'(1);
						state_q <= ntt_pkg::S_ST_START;
					end else begin
						i_q <= i_q + IW'(1);
						state_q <= ntt_pkg::S_BR_RD;
					end
				end
				// stage twiddle root
				ntt_pkg::S_ST_START: begin
					if (s_q > ntt_pkg::S_W'(lg_q)) begin
						state_q <= inv_q ? ntt_pkg::S_INV_START : ntt_pkg::S_IDLE;
					end else begin
						pow_ret_q <= ntt_pkg::S_ST_INV;
						state_q <= ntt_pkg::S_P_CHK;
					end
				end
				ntt_pkg::S_ST_INV: begin
					pow_ret_q <= ntt_pkg::S_ST_WSET;
					state_q <= inv_q ? ntt_pkg::S_P_CHK : ntt_pkg::S_ST_WSET;
				end
				ntt_pkg::S_ST_WSET: begin
					i_q <= '0;
					j_q <= IW'(1);
					state_q <= (half == IW'(1)) ? ntt_pkg::S_BF_RD : ntt_pkg::S_TW_MUL;
					if (half == IW'(1)) begin
						j_q <= '0;
					end
				end
				// twiddle table of the stage
				ntt_pkg::S_TW_MUL: begin
					mcnt_q <= '0;
					mul_ret_q <= ntt_pkg::S_TW_WR;
					state_q <= ntt_pkg::S_MUL;
				end
				ntt_pkg::S_TW_WR: begin
					if (j_q + IW'(1) == half) begin
						j_q <= '0;
						state_q <= ntt_pkg::S_BF_RD;
					end else begin
						j_q <= j_q + IW'(1);
						state_q <= ntt_pkg::S_TW_MUL;
					end
				end
				// butterflies
				ntt_pkg::S_BF_RD: state_q <= ntt_pkg::S_BF_MUL;
				ntt_pkg::S_BF_MUL: begin
					mcnt_q <= '0;
					mul_ret_q <= ntt_pkg::S_BF_WR1;
					state_q <= ntt_pkg::S_MUL;
				end
				ntt_pkg::S_BF_WR1: state_q <= ntt_pkg::S_BF_WR2;
				ntt_pkg::S_BF_WR2: begin
					if (j_q + IW'(1) != half) begin
						j_q <= j_q + IW'(1);
						state_q <= ntt_pkg::S_BF_RD;
					end else if (i_q + len != n_q) begin
						j_q <= '0;
						i_q <= i_q + len;
						state_q <= ntt_pkg::S_BF_RD;
					end else begin
						j_q <= '0;
						i_q <= '0;
						s_q <= s_q + ntt_pkg::S_W'(1);
						state_q <= ntt_pkg::S_ST_START;
					end
				end
				// inverse scaling by n^-1
				ntt_pkg::S_INV_START: begin
					mcnt_q <= '0;
					mul_ret_q <= ntt_pkg::S_INV_P;
					state_q <= ntt_pkg::S_MUL;
				end
				ntt_pkg::S_INV_P: begin
					i_q <= '0;
					pow_ret_q <= ntt_pkg::S_SC_RD;
					state_q <= ntt_pkg::S_P_CHK;
				end
				ntt_pkg::S_SC_RD: state_q <= ntt_pkg::S_SC_MUL;
				ntt_pkg::S_SC_MUL: begin
					mcnt_q <= '0;
					mul_ret_q <= ntt_pkg::S_SC_WR;
					state_q <= ntt_pkg::S_MUL;
				end
				ntt_pkg::S_SC_WR: begin
					if (i_q + IW'(1) == n_q) begin
						i_q <= '0;
						state_q <= ntt_pkg::S_IDLE;
					end else begin
						i_q <= i_q + IW'(1);
						state_q <= ntt_pkg::S_SC_RD;
					end
				end
				// square and multiply, exponent from the low bit
				ntt_pkg::S_P_CHK: begin
					if (pe_q == '0) begin
						state_q <= pow_ret_q;
					end else if (pe_q[0]) begin
						mcnt_q <= '0;
						mul_ret_q <= ntt_pkg::S_P_SQ1;
						state_q <= ntt_pkg::S_MUL;
					end else begin
						state_q <= ntt_pkg::S_P_SQ;
					end
				end
				ntt_pkg::S_P_SQ1: state_q <= ntt_pkg::S_P_SQ;
				ntt_pkg::S_P_SQ: begin
					mcnt_q <= '0;
					mul_ret_q <= ntt_pkg::S_P_SQ2;
					state_q <= ntt_pkg::S_MUL;
				end
				ntt_pkg::S_P_SQ2: state_q <= ntt_pkg::S_P_CHK;
				// shared modular multiplier, one multiplier bit a cycle
				ntt_pkg::S_MUL: begin
					if (mcnt_q == 6'(DW - 1)) begin
						mcnt_q <= '0;
						state_q <= mul_ret_q;
					end else begin
						mcnt_q <= mcnt_q + 6'd1;
					end
				end
				default: state_q <= ntt_pkg::S_IDLE;
			endcase
		end
	end

	`include "assert_macros.svh"

	// partial product stays reduced while the multiplier runs
	`ASSERT_IMPLIES(a_mul_reduced, clk, arst_n, state_q == ntt_pkg::S_MUL, mr_q < m_q)
	// transform writes stay inside the length in use
	`ASSERT_IMPLIES(a_wr_range, clk, arst_n, ce_we && !s_tready, IW'(ce_wa) < n_q)
	// an out-of-range read returns zero
	`ASSERT_IMPLIES(a_bad_zero, clk, arst_n, ov_q && obad_q, oval_q == '0)
	// multiplier count only advances inside the multiplier
	`ASSERT_IMPLIES(a_cnt_idle, clk, arst_n, state_q != ntt_pkg::S_MUL, mcnt_q == '0)

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench of the number theoretic transform block
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned NPTS = 1024;
	localparam int unsigned STALL_LIMIT = 4000000;
	localparam int unsigned DW = ntt_pkg::DW;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ntt_pkg::CFG_AW-1:0] cfg_addr = ntt_pkg::REG_MODULUS;
	logic [DW-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic s_tuser = ntt_pkg::CMD_LOAD;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic m_tuser;

	always #2 clk = ~clk;

	number_theoretic_transform #(.MAX_POINTS(NPTS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// expected read results
	typedef struct packed {
		logic [DW-1:0] value;
		logic bad_index;
	} read_res_t;

	read_res_t pending_reads[$];
	int unsigned n_errors = 0;
	int unsigned idle_cycles = 0;

	// shadow of the block: registers, stores, batch position
	logic [63:0] sh_mod, sh_root;
	logic sh_inv;
	logic [3:0] sh_log;
	logic [63:0] sh_coeff[NPTS];
	logic [63:0] sh_twid[NPTS];
	bit sh_loaded[NPTS];
	int unsigned sh_count;

	function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [63:0] r;
		r = 0;
		for (int bit_i = 61; bit_i >= 0; bit_i--) begin
			r = r << 1;
			if (r >= m) r -= m;
			if (b[bit_i]) begin
				r += a;
				if (r >= m) r -= m;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
		logic [63:0] r;
		r = 64'd1 % m;
		base = base % m;
		while (e != 0) begin
			if (e[0]) r = mulmod(r, base, m);
			base = mulmod(base, base, m);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic int unsigned size_log();
		return (sh_log > 4'd10) ? 10 : sh_log;
	endfunction

	// reduction, reorder, staged butterflies and optional 1/n scaling on the shadow store
	function automatic void transform_batch(int unsigned lg);
		int unsigned n, rev, half;
		logic [63:0] m, g, w, u, v, s, d, t, inv_n;
		n = 1 << lg;
		m = (sh_mod < 2) ? 64'd1 : sh_mod;
		g = sh_root % m;
		for (int i = 0; i < n; i++) sh_coeff[i] = sh_coeff[i] % m;
		for (int i = 0; i < n; i++) begin
			rev = 0;
			for (int k = 0; k < lg; k++) rev |= ((i >> k) & 1) << (lg - 1 - k);
			if (i < rev) begin
				t = sh_coeff[i];
				sh_coeff[i] = sh_coeff[rev];
				sh_coeff[rev] = t;
			end
		end
		for (int len = 2; len <= n; len <<= 1) begin
			half = len >> 1;
			w = powmod(g, (m - 1) / len, m);
			if (sh_inv) w = powmod(w, (m >= 2) ? m - 2 : 0, m);
			sh_twid[half] = 64'd1 % m;
			for (int j = 1; j < half; j++)
				sh_twid[half + j] = mulmod(sh_twid[half + j - 1], w, m);
			for (int i = 0; i < n; i += len) begin
				for (int j = 0; j < half; j++) begin
					u = sh_coeff[i + j];
					v = mulmod(sh_coeff[i + j + half], sh_twid[half + j], m);
					s = u + v;
					d = u + m - v;
					if (s >= m) s -= m;
					if (d >= m) d -= m;
					sh_coeff[i + j] = s;
					sh_coeff[i + j + half] = d;
				end
			end
		end
		if (sh_inv) begin
			inv_n = powmod(n % m, (m >= 2) ? m - 2 : 0, m);
			for (int i = 0; i < n; i++) sh_coeff[i] = mulmod(sh_coeff[i], inv_n, m);
		end
	endfunction

	// advance the shadow by one accepted item
	function automatic void track_item(logic cmd, logic [DW-1:0] coeff, logic [9:0] idx);
		int unsigned lg, n;
		read_res_t r;
		lg = size_log();
		n = 1 << lg;
		if (cmd == ntt_pkg::CMD_LOAD) begin
			if (sh_count < NPTS) begin
				sh_coeff[sh_count] = coeff;
				sh_loaded[sh_count] = 1'b1;
			end
			sh_count++;
			if (sh_count >= n) begin
				transform_batch(lg);
				sh_count = 0;
			end
		end else begin
			if (idx >= n) r = '{value: '0, bad_index: 1'b1};
			else r = '{value: sh_coeff[idx][DW-1:0], bad_index: 1'b0};
			pending_reads.push_back(r);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		read_res_t want;
		if (m_tvalid && m_tready) begin
			if (pending_reads.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("unexpected item: value %0h bad %0b",
					m_tdata[DW-1:0], m_tuser);
			end else begin
				want = pending_reads.pop_front();
				if (m_tdata[DW-1:0] !== want.value || m_tdata[63:DW] !== '0 ||
						m_tuser !== want.bad_index) begin
					n_errors++;
					if (n_errors <= 10) $display("mismatch: exp value %0h bad %0b, got %0h bad %0b",
						want.value, want.bad_index, m_tdata, m_tuser);
				end
			end
		end
	end

	// receiver stalls: alternating calm and stalling stretches
	always @(negedge clk) begin
		int unsigned phase_len;
		if (phase_len == 0) phase_len = $urandom_range(5, 60);
		phase_len--;
		if ((phase_len / 20) % 2 == 0) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	int unsigned burst_left = 0;

	// drive one item at a falling edge, hold until taken, then maybe gap
	task automatic send_item(logic cmd, logic [DW-1:0] coeff, logic [9:0] idx);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {idx, coeff};
		do @(posedge clk); while (!s_tready);
		track_item(cmd, coeff, idx);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// drain results and let any transform in flight finish before a register write
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		wait (pending_reads.size() == 0);
		repeat (8) @(negedge clk);
		while (!s_tready) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [ntt_pkg::CFG_AW-1:0] addr, logic [DW-1:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (addr)
			ntt_pkg::REG_MODULUS: sh_mod = data;
			ntt_pkg::REG_ROOT: sh_root = data;
			ntt_pkg::REG_INVERSE: sh_inv = data[0];
			default: sh_log = data[3:0];
		endcase
	endtask

	task automatic set_config(logic [DW-1:0] m, logic [DW-1:0] g, logic inv, logic [3:0] lg);
		write_reg(ntt_pkg::REG_MODULUS, m);
		write_reg(ntt_pkg::REG_ROOT, g);
		write_reg(ntt_pkg::REG_INVERSE, {61'd0, inv});
		write_reg(ntt_pkg::REG_LOG, {58'd0, lg});
	endtask

	function automatic logic [DW-1:0] rand_coeff();
		logic [63:0] r;
		r = {$urandom, $urandom};
		if ($urandom_range(0, 1) == 0) return r[DW-1:0] % sh_mod;
		return r[DW-1:0];
	endfunction

	// pick a read index that never hits an entry not yet written
	function automatic logic [9:0] rand_index();
		int unsigned n, idx;
		n = 1 << size_log();
		if ($urandom_range(0, 4) != 0) idx = $urandom_range(0, n - 1);
		else idx = $urandom_range(0, NPTS - 1);
		if (idx < n && !sh_loaded[idx]) idx = (n == NPTS) ? 0 : n;
		return idx[9:0];
	endfunction

	// directed rows: kind, coeff, index, whether the result is typed in, expected
	typedef struct {
		logic cmd;
		logic [DW-1:0] coeff;
		logic [9:0] idx;
		bit fixed;
		logic [DW-1:0] value;
		logic bad;
	} row_t;

	localparam logic [DW-1:0] ALL1 = {DW{1'b1}};

	row_t rows[] = '{
		// impulse transforms to all ones
		'{ntt_pkg::CMD_LOAD, 62'd1, 10'd0, 0, 0, 0},
		'{ntt_pkg::CMD_LOAD, 62'd0, 10'd0, 0, 0, 0},
		'{ntt_pkg::CMD_READ, 62'd0, 10'd0, 1, 62'd1, 0},
		'{ntt_pkg::CMD_LOAD, 62'd0, 10'd0, 0, 0, 0},
		'{ntt_pkg::CMD_LOAD, 62'd0, 10'd0, 0, 0, 0},
		'{ntt_pkg::CMD_READ, 62'd0, 10'd0, 1, 62'd1, 0},
		'{ntt_pkg::CMD_READ, 62'd0, 10'd3, 1, 62'd1, 0},
		// indexes past the length in use
		'{ntt_pkg::CMD_READ, 62'd0, 10'd4, 1, 62'd0, 1},
		'{ntt_pkg::CMD_READ, 62'd0, 10'd1023, 1, 62'd0, 1},
		// unreduced and extreme coefficients
		'{ntt_pkg::CMD_LOAD, ALL1, 10'd0, 0, 0, 0},
		'{ntt_pkg::CMD_LOAD, 62'd16, 10'd0, 0, 0, 0},
		'{ntt_pkg::CMD_LOAD, 62'd17, 10'd0, 0, 0, 0},
		'{ntt_pkg::CMD_READ, 62'd0, 10'd2, 0, 0, 0},
		'{ntt_pkg::CMD_LOAD, 62'd5, 10'd0, 0, 0, 0},
		'{ntt_pkg::CMD_READ, 62'd0, 10'd0, 0, 0, 0},
		'{ntt_pkg::CMD_READ, 62'd0, 10'd1, 0, 0, 0},
		'{ntt_pkg::CMD_READ, 62'd0, 10'd2, 0, 0, 0},
		'{ntt_pkg::CMD_READ, 62'd0, 10'd3, 0, 0, 0}
	};

	// random phases: modulus, root, inverse, log size, batches
	typedef struct {
		logic [DW-1:0] m;
		logic [DW-1:0] g;
		logic inv;
		logic [3:0] lg;
		int unsigned batches;
	} phase_t;

	phase_t phases[] = '{
		'{62'd998244353, 62'd3, 1'b0, 4'd15, 1},
		'{62'd998244353, 62'd3, 1'b1, 4'd3, 2},
		'{62'd17, 62'd3, 1'b1, 4'd2, 3},
		'{62'd3, 62'd1, 1'b0, 4'd1, 3},
		'{62'd4179340454199820289, 62'd3, 1'b0, 4'd3, 2},
		'{62'd4179340454199820289, 62'd3, 1'b1, 4'd2, 3},
		'{ALL1, ALL1, 1'b1, 4'd2, 2},
		'{62'd7681, 62'd17, 1'b0, 4'd0, 6},
		'{62'd7681, 62'd17, 1'b1, 4'd0, 4},
		'{62'd12289, 62'd11, 1'b1, 4'd4, 1},
		'{62'd998244353, 62'd3, 1'b0, 4'd1, 4}
	};

	initial begin
		int unsigned n, loads_left, reads_left;
		read_res_t typed;
		sh_mod = ntt_pkg::RST_MODULUS;
		sh_root = ntt_pkg::RST_ROOT;
		sh_inv = 1'b0;
		sh_log = ntt_pkg::RST_LOG;
		sh_count = 0;
		foreach (sh_coeff[i]) begin
			sh_coeff[i] = 0;
			sh_twid[i] = 0;
			sh_loaded[i] = 0;
		end
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed part
		set_config(62'd17, 62'd3, 1'b0, 4'd2);
		foreach (rows[r]) begin
			send_item(rows[r].cmd, rows[r].coeff, rows[r].idx);
			if (rows[r].fixed) begin
				typed = '{value: rows[r].value, bad_index: rows[r].bad};
				if (pending_reads[$] !== typed) begin
					n_errors++;
					if (n_errors <= 10) $display("directed row %0d: table and prediction differ", r);
				end
			end
		end

		// random part
		foreach (phases[p]) begin
			wait_quiet();
			set_config(phases[p].m, phases[p].g, phases[p].inv, phases[p].lg);
			n = 1 << size_log();
			loads_left = n * phases[p].batches;
			reads_left = (n == NPTS) ? 40 : 10 + loads_left;
			while (loads_left > 0 || reads_left > 0) begin
				if (loads_left > 0 && (reads_left == 0 || sh_count + 1 < n || sh_count == 0 ||
						$urandom_range(0, 2) == 0) &&
						(reads_left == 0 || $urandom_range(0, 99) < ((n == NPTS) ? 90 : 40))) begin
					send_item(ntt_pkg::CMD_LOAD, rand_coeff(), $urandom_range(0, NPTS - 1));
					loads_left--;
				end else if (reads_left > 0) begin
					send_item(ntt_pkg::CMD_READ, rand_coeff(), rand_index());
					reads_left--;
				end else begin
					send_item(ntt_pkg::CMD_LOAD, rand_coeff(), $urandom_range(0, NPTS - 1));
					loads_left--;
				end
			end
		end

		// drain and settle
		s_tvalid <= 1'b0;
		wait (pending_reads.size() == 0);
		repeat (50) @(negedge clk);
		if (n_errors == 0 && pending_reads.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
